FILE: hw/rtl/fsw_pkg.sv
package fsw_pkg;

  // Field widths of the request and result channels
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned WEIGHT_W = 25;
  localparam int unsigned TOTAL_W  = 35;

  // Scaling of the variance before the root: 17.8 fixed point weight
  localparam int unsigned FRAC_SHIFT = 16;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                first_of_set;
    logic                last_of_feature;
  } fsw_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    feature_index;
    logic [WEIGHT_W-1:0] weight_q8;
    logic [TOTAL_W-1:0]  cumulative_q8;
  } fsw_res_t;

  // Top level to arithmetic unit
  typedef struct packed {
    logic start;
    logic ack;
  } fsw_ctrl_t;

  // Arithmetic unit to top level
  typedef struct packed {
    logic busy;
    logic done;
  } fsw_stat_t;

endpackage

FILE: hw/rtl/fsw_stream_if.sv
interface fsw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/fsw_arith.sv
module fsw_arith #(
  parameter int unsigned MAX_SAMPLES = 65536,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SUM_W = $clog2(64'(MAX_SAMPLES) * 64'd255 + 64'd1),
  localparam int unsigned SQ_W  = $clog2(64'(MAX_SAMPLES) * 64'd65025 + 64'd1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fsw_pkg::fsw_ctrl_t              ctrl_i,
  output fsw_pkg::fsw_stat_t              stat_o,
  input  logic [CNT_W-1:0]                count_i,
  input  logic [SUM_W-1:0]                vsum_i,
  input  logic [SQ_W-1:0]                 ssum_i,
  output logic [fsw_pkg::WEIGHT_W-1:0]    weight_o
);
  import fsw_pkg::*;

  localparam int unsigned PROD_W = CNT_W + SQ_W;
  localparam int unsigned DVD_W  = PROD_W + FRAC_SHIFT;
  localparam int unsigned RAD_W  = ((SQ_W + FRAC_SHIFT + 1) / 2) * 2;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned ALU_W  = (PROD_W > ROOT_W + 2) ? PROD_W : ROOT_W + 2;
  localparam int unsigned STEP_W = $clog2(DVD_W + 1);
  localparam int unsigned RW     = (ROOT_W > WEIGHT_W) ? ROOT_W : WEIGHT_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULQ = 3'd1;
  localparam logic [2:0] S_MULS = 3'd2;
  localparam logic [2:0] S_DIFF = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  mpl_q, mpl_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] sqr_q, sqr_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic [ALU_W-1:0]  alu_a, alu_b;
  logic              alu_sub;
  logic [ALU_W:0]    alu_res;
  logic              alu_ge;

  logic              last_step;
  logic [CNT_W:0]    div_shift;
  logic [ROOT_W+1:0] root_trial_rem;
  logic [ROOT_W+1:0] root_trial;
  logic [PROD_W-1:0] diff;
  logic [RW-1:0]     root_ext;

  // Shared adder/subtractor; carry out means a >= b when subtracting
  always_comb begin
    alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (ALU_W + 1)'(alu_sub);
    alu_ge  = alu_res[ALU_W];
  end

  assign last_step      = (step_q == STEP_W'(1));
  assign div_shift      = {rem_q, dvd_q[DVD_W-1]};
  assign root_trial_rem = {sqr_q, dvd_q[RAD_W-1:RAD_W-2]};
  assign root_trial     = {root_q, 2'b01};
  // n*Q >= S*S always holds; clamp anyway
  assign diff           = alu_ge ? alu_res[PROD_W-1:0] : '0;

  // Operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_MULQ: begin
        alu_a = ALU_W'({acc_q[PROD_W-2:0], 1'b0});
        alu_b = mpl_q[SUM_W-1] ? ALU_W'(ssum_i) : '0;
      end
      S_MULS: begin
        alu_a = ALU_W'({acc_q[PROD_W-2:0], 1'b0});
        alu_b = mpl_q[SUM_W-1] ? ALU_W'(vsum_i) : '0;
      end
      S_DIFF: begin
        alu_a   = ALU_W'(prod_q);
        alu_b   = ALU_W'(acc_q);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = ALU_W'(div_shift);
        alu_b   = ALU_W'(count_i);
        alu_sub = 1'b1;
      end
      S_ROOT: begin
        alu_a   = ALU_W'(root_trial_rem);
        alu_b   = ALU_W'(root_trial);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Sequencer: n*Q, S*S, difference, scaled divide by n, square root
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mpl_d   = mpl_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    sqr_d   = sqr_q;
    root_d  = root_q;
    unique case (state_q)
      S_IDLE: begin
        if (ctrl_i.start) begin
          state_d = S_MULQ;
          step_d  = STEP_W'(SUM_W);
          mpl_d   = SUM_W'(count_i);
          acc_d   = '0;
        end
      end
      S_MULQ: begin
        mpl_d  = {mpl_q[SUM_W-2:0], 1'b0};
        acc_d  = alu_res[PROD_W-1:0];
        step_d = step_q - STEP_W'(1);
        if (last_step) begin
          prod_d  = alu_res[PROD_W-1:0];
          acc_d   = '0;
          mpl_d   = vsum_i;
          step_d  = STEP_W'(SUM_W);
          state_d = S_MULS;
        end
      end
      S_MULS: begin
        mpl_d  = {mpl_q[SUM_W-2:0], 1'b0};
        acc_d  = alu_res[PROD_W-1:0];
        step_d = step_q - STEP_W'(1);
        if (last_step) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        dvd_d   = {diff, {FRAC_SHIFT{1'b0}}};
        rem_d   = '0;
        step_d  = STEP_W'(DVD_W);
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = alu_ge ? alu_res[CNT_W-1:0] : div_shift[CNT_W-1:0];
        dvd_d  = {dvd_q[DVD_W-2:0], alu_ge};
        step_d = step_q - STEP_W'(1);
        if (last_step) begin
          sqr_d   = '0;
          root_d  = '0;
          step_d  = STEP_W'(ROOT_W);
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        sqr_d  = alu_ge ? alu_res[ROOT_W-1:0] : root_trial_rem[ROOT_W-1:0];
        root_d = {root_q[ROOT_W-2:0], alu_ge};
        dvd_d  = {dvd_q[DVD_W-3:0], 2'b00};
        step_d = step_q - STEP_W'(1);
        if (last_step) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (ctrl_i.ack) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mpl_q  <= mpl_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    sqr_q  <= sqr_d;
    root_q <= root_d;
  end

  // Weight saturates at the field top
  assign root_ext = RW'(root_q);
  assign weight_o = (|root_ext[RW-1:WEIGHT_W]) ? '1 : root_ext[WEIGHT_W-1:0];

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);

endmodule

FILE: hw/rtl/feature_spread_weight_table.sv
// Samples: one request per cycle while no column end is in work; a sample that does not
// end a column completes at once. Column end: the result is set by the bit-serial
//   multiply, divide and root steps of one shared adder; no request is taken until the
//   weight has gone into the result register.
// The result register lets sampling of the next column go on while a result waits.
// Reset (asynchronous, active low) clears all sums, counters, the total and the result valid flag.
module feature_spread_weight_table #(
  parameter int unsigned MAX_SAMPLES  = 65536,
  parameter int unsigned MAX_FEATURES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fsw_stream_if.sink   req_i,
  fsw_stream_if.source res_o
);
  import fsw_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = $clog2(64'(MAX_SAMPLES) * 64'd255 + 64'd1);
  localparam int unsigned SQ_W  = $clog2(64'(MAX_SAMPLES) * 64'd65025 + 64'd1);
  localparam int unsigned FEAT_TOP_I = (MAX_FEATURES - 1 > (2 ** IDX_W) - 1) ?
                                       (2 ** IDX_W) - 1 : MAX_FEATURES - 1;
  localparam logic [IDX_W-1:0] FEAT_TOP  = IDX_W'(FEAT_TOP_I);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SAMPLES);

  fsw_ctrl_t ctrl;
  fsw_stat_t stat;

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    vsum_q, vsum_d;
  logic [SQ_W-1:0]     ssum_q, ssum_d;
  logic [IDX_W-1:0]    feat_q, feat_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                start_q, start_d;
  logic                out_valid_q, out_valid_d;
  fsw_res_t            out_q, out_d;

  logic                accept;
  logic [WEIGHT_W-1:0] weight;
  logic [TOTAL_W:0]    total_sum;
  logic [TOTAL_W-1:0]  total_new;
  logic [2*SAMPLE_W-1:0] sample_sq;

  // Request handshake: closed while a column is being worked out
  assign req_i.ready = !start_q && !stat.busy;
  assign accept      = req_i.valid && req_i.ready;

  // Hand the column over once the sums include its last sample
  assign ctrl.start = start_q;
  assign ctrl.ack   = stat.done && (!out_valid_q || res_o.ready);

  assign sample_sq = req_i.data.sample_value * req_i.data.sample_value;
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(weight);
  assign total_new = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  // Accumulators, feature counter and running total
  always_comb begin
    cnt_d   = cnt_q;
    vsum_d  = vsum_q;
    ssum_d  = ssum_q;
    feat_d  = feat_q;
    total_d = total_q;
    start_d = accept && req_i.data.last_of_feature;
    if (ctrl.ack) begin
      cnt_d   = '0;
      vsum_d  = '0;
      ssum_d  = '0;
      total_d = total_new;
      if (feat_q < FEAT_TOP) begin
        feat_d = feat_q + IDX_W'(1);
      end
    end
    if (accept) begin
      if (req_i.data.first_of_set) begin
        total_d = '0;
        feat_d  = '0;
      end
      // Column too long: further samples are dropped
      if (cnt_q < CNT_LIMIT) begin
        cnt_d  = cnt_q + CNT_W'(1);
        vsum_d = vsum_q + SUM_W'(req_i.data.sample_value);
        ssum_d = ssum_q + SQ_W'(sample_sq);
      end
    end
  end

  // Result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.ack) begin
      out_valid_d         = 1'b1;
      out_d.feature_index = feat_q;
      out_d.weight_q8     = weight;
      out_d.cumulative_q8 = total_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      vsum_q      <= '0;
      ssum_q      <= '0;
      feat_q      <= '0;
      total_q     <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      vsum_q      <= vsum_d;
      ssum_q      <= ssum_d;
      feat_q      <= feat_d;
      total_q     <= total_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // Multiply, divide and root unit
  fsw_arith #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .count_i (cnt_q),
    .vsum_i  (vsum_q),
    .ssum_i  (ssum_q),
    .weight_o(weight)
  );

`ifndef ASSERT_OFF
  a_start_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> stat.busy)
    else $error("column start not taken by arithmetic unit");

  a_ack_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ack |-> stat.done)
    else $error("result taken before the weight is ready");

  a_no_request_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> !accept)
    else $error("request accepted while a weight waits");

  a_feat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feat_q <= FEAT_TOP)
    else $error("feature counter beyond its top");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LIMIT)
    else $error("sample count beyond its limit");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import fsw_pkg::*;

  localparam int unsigned MAX_SAMPLES  = 65536;
  localparam int unsigned MAX_FEATURES = 1024;
  localparam int unsigned INDEX_TOP    = (MAX_FEATURES - 1 > 1023) ? 1023 : MAX_FEATURES - 1;
  localparam longint unsigned WEIGHT_MAX = (64'd1 << WEIGHT_W) - 1;
  localparam longint unsigned TOTAL_MAX  = (64'd1 << TOTAL_W) - 1;
  localparam int unsigned SAT_COLUMNS  = 1030;
  localparam int unsigned RAND_SAMPLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 300;

  // How the samples of a generated column are filled
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FLAT, FILL_EXTREME, FILL_LOW} fill_e;

  typedef struct {
    fsw_req_t    req;
    int unsigned gap_after;
    bit          hold;
  } pending_t;

  logic clk_i;
  logic rst_ni;

  fsw_stream_if #(.payload_t(fsw_req_t)) req_if ();
  fsw_stream_if #(.payload_t(fsw_res_t)) res_if ();

  feature_spread_weight_table #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_FEATURES(MAX_FEATURES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // Predicted state of the column accumulators and the roulette table
  logic [23:0]        col_sum;
  logic [31:0]        col_sq;
  logic [16:0]        col_count;
  logic [IDX_W-1:0]   feature_idx;
  logic [TOTAL_W-1:0] table_total;

  pending_t    pending_reqs[$];
  fsw_res_t    expected_rows[$];
  int unsigned samples_total;
  int unsigned samples_sent;
  int unsigned rows_checked;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned idle_left;
  int unsigned stall_left;

  // floor(sqrt(floor((n*q - s*s) * 2^16 / n))), zero when no squares
  function automatic longint unsigned spread_weight_q8(input longint unsigned n,
                                                       input longint unsigned s,
                                                       input longint unsigned q);
    longint unsigned diff;
    longint unsigned scaled;
    longint unsigned root;
    longint unsigned trial;
    if (q == 0 || n == 0) return 0;
    diff   = (n * q >= s * s) ? n * q - s * s : 0;
    scaled = ((diff / n) << FRAC_SHIFT) + (((diff % n) << FRAC_SHIFT) / n);
    root   = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    return (root > WEIGHT_MAX) ? WEIGHT_MAX : root;
  endfunction

  // Fold one accepted sample into the column; a column end yields a table row
  task automatic predict_column_end(input fsw_req_t r);
    fsw_res_t        row;
    longint unsigned w;
    longint unsigned t;
    if (r.first_of_set) begin
      table_total = '0;
      feature_idx = '0;
    end
    if (col_count < MAX_SAMPLES) begin
      col_sum   = col_sum + 24'(r.sample_value);
      col_sq    = col_sq + 32'(r.sample_value) * 32'(r.sample_value);
      col_count = col_count + 17'd1;
    end
    if (r.last_of_feature) begin
      w = spread_weight_q8(col_count, col_sum, col_sq);
      t = longint'(table_total) + w;
      if (t > TOTAL_MAX) t = TOTAL_MAX;
      table_total       = t[TOTAL_W-1:0];
      row.feature_index = feature_idx;
      row.weight_q8     = w[WEIGHT_W-1:0];
      row.cumulative_q8 = table_total;
      expected_rows.push_back(row);
      if (feature_idx < INDEX_TOP) feature_idx = feature_idx + 1'b1;
      col_sum   = '0;
      col_sq    = '0;
      col_count = '0;
    end
  endtask

  // Queue one request; the gap is the idle time before the next one
  task automatic push_sample(input logic [SAMPLE_W-1:0] v, input bit first, input bit last,
                             input bit calm, input bit hold);
    pending_t    p;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    p.req.sample_value    = v;
    p.req.first_of_set    = first;
    p.req.last_of_feature = last;
    p.hold                = hold;
    if (calm || roll < 50) p.gap_after = 0;
    else if (roll < 85) p.gap_after = $urandom_range(1, 3);
    else if (roll < 96) p.gap_after = $urandom_range(4, 8);
    else p.gap_after = $urandom_range(15, 40);
    pending_reqs.push_back(p);
    samples_total++;
  endtask

  // Queue a whole column; noisy columns may carry a stray set start mid-column
  task automatic push_column(input int unsigned len, input fill_e fill, input bit fos,
                             input bit calm, input bit noisy, input bit hold);
    logic [SAMPLE_W-1:0] flat_v;
    logic [SAMPLE_W-1:0] v;
    bit                  first;
    flat_v = 8'($urandom());
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO:    v = '0;
        FILL_FLAT:    v = flat_v;
        FILL_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        FILL_LOW:     v = 8'($urandom_range(0, 3));
        default:      v = 8'($urandom());
      endcase
      first = (i == 0) ? fos : (noisy && $urandom_range(0, 63) == 0);
      push_sample(v, first, i == len - 1, calm, hold && i == 0);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[feature_spread_weight_table] ERROR");
      $finish;
    end
  end

  // Request driver: predicts on acceptance, then offers the next pending request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_column_end(req_if.data);
        samples_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold && expected_rows.size() != 0)) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_reqs[0].req;
          idle_left = pending_reqs[0].gap_after;
          pending_reqs.delete(0);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure; calm spells have none
  always @(posedge clk_i) begin
    fsw_res_t want;
    fsw_res_t got;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (expected_rows.size() == 0) begin
          $error("unexpected result: feature_index %0d weight_q8 %0d cumulative_q8 %0d",
                 got.feature_index, got.weight_q8, got.cumulative_q8);
          err_count++;
        end else begin
          want = expected_rows.pop_front();
          rows_checked++;
          if (got.feature_index !== want.feature_index) begin
            $error("feature_index: expected %0d, got %0d", want.feature_index,
                   got.feature_index);
            err_count++;
          end
          if (got.weight_q8 !== want.weight_q8) begin
            $error("weight_q8: expected %0d, got %0d", want.weight_q8, got.weight_q8);
            err_count++;
          end
          if (got.cumulative_q8 !== want.cumulative_q8) begin
            $error("cumulative_q8: expected %0d, got %0d", want.cumulative_q8,
                   got.cumulative_q8);
            err_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ((cycle_count / 1500) % 5 != 0 && $urandom_range(0, 9) == 0) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 5);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned rand_sent;
    int unsigned len;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
    rst_ni       = 1'b0;
    col_sum      = '0;
    col_sq       = '0;
    col_count    = '0;
    feature_idx  = '0;
    table_total  = '0;

    // Single full-scale sample: squares but no spread
    push_sample(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
    // All-zero column hits the zero spread guard
    push_column(3, FILL_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
    // Widest spread
    push_sample(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_sample(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    push_sample(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_sample(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
    // Flat non-zero column
    push_column(3, FILL_FLAT, 1'b0, 1'b0, 1'b0, 1'b0);
    // Smallest non-zero spread
    push_sample(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    push_sample(8'h01, 1'b0, 1'b1, 1'b1, 1'b0);
    // Set start in the middle of a column keeps the sums
    push_sample(8'd17, 1'b0, 1'b0, 1'b0, 1'b0);
    push_sample(8'd200, 1'b0, 1'b0, 1'b0, 1'b0);
    push_sample(8'd3, 1'b1, 1'b0, 1'b0, 1'b0);
    push_sample(8'd90, 1'b0, 1'b0, 1'b0, 1'b0);
    push_sample(8'd250, 1'b0, 1'b1, 1'b0, 1'b0);
    // Set start and column end on one request, after draining
    push_sample(8'd128, 1'b1, 1'b1, 1'b0, 1'b1);

    // Long run of short columns takes the feature index to its top
    for (int unsigned k = 0; k < SAT_COLUMNS; k++)
      push_column((k % 32 == 31) ? 2 : 1, FILL_RANDOM, k == 0, k % 64 < 8, 1'b0, 1'b0);

    // Random sets of columns
    rand_sent = 0;
    while (rand_sent < RAND_SAMPLES) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 8);
      push_column(len, fill_e'($urandom_range(0, 4)), $urandom_range(0, 19) == 0,
                  $urandom_range(0, 7) == 0, 1'b1, $urandom_range(0, 39) == 0);
      rand_sent += len;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (samples_sent < samples_total || expected_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run streamed %0d samples and checked %0d table rows: edge columns,",
             samples_sent, rows_checked);
    $display("index saturation and random sets; %0d failures.", err_count);
    if (err_count == 0) begin
      $display("[feature_spread_weight_table] OK");
    end else begin
      $display("[feature_spread_weight_table] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fsw_pkg.sv
hw/rtl/fsw_stream_if.sv
hw/rtl/fsw_arith.sv
hw/rtl/feature_spread_weight_table.sv
tb/tb_top.sv
